### src/ptsr_pkg.sv
package ptsr_pkg;

   // Item opcodes carried on the request channel.
   typedef logic [1:0] ptsr_op_type;
   localparam ptsr_op_type OP_BYTE  = 2'd0;
   localparam ptsr_op_type OP_PULSE = 2'd1;
   localparam ptsr_op_type OP_QUERY = 2'd2;

   // Frame parser states.
   typedef enum logic [1:0] {
      PS_WAIT_FIRST  = 2'd0,
      PS_WAIT_SECOND = 2'd1,
      PS_GATHER      = 2'd2,
      PS_LOADED      = 2'd3
   } ptsr_parse_state_type;

   localparam logic [7:0] MAGIC_FIRST  = 8'h16;
   localparam logic [7:0] MAGIC_SECOND = 8'h03;

   // Default scale factor: 1e9 / 72000065 ns per cycle in Q8.24.
   localparam logic [31:0] NS_PER_CYCLE_RESET = 32'd233016679;
   localparam int unsigned FRAC_BITS = 24;

   localparam int unsigned SEC_W = 32;
   localparam int unsigned NS_W  = 32;

   // One item step handed to the time keeper.
   typedef struct packed {
      logic        valid;
      ptsr_op_type op;
      logic [7:0]  data;
   } ptsr_step_type;

   // Time-of-day state as it stands after the step in flight.
   typedef struct packed {
      logic [SEC_W-1:0] seconds;
      logic             time_set;
   } ptsr_time_type;

endpackage

### src/ptsr_time_keeper.sv
module ptsr_time_keeper
   import ptsr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ptsr_step_type step,
   output ptsr_time_type time_next
);

   ptsr_parse_state_type state_ff, state_in;
   logic [1:0]           index_ff, index_in;
   logic [23:0]          gather_ff, gather_in;
   logic [SEC_W-1:0]     seconds_ff, seconds_in;
   logic                 set_ff, set_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= PS_WAIT_FIRST;
         index_ff   <= 2'd0;
         gather_ff  <= 24'd0;
         seconds_ff <= '0;
         set_ff     <= 1'b0;
      end else if (step.valid) begin
         state_ff   <= state_in;
         index_ff   <= index_in;
         gather_ff  <= gather_in;
         seconds_ff <= seconds_in;
         set_ff     <= set_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      index_in   = index_ff;
      gather_in  = gather_ff;
      seconds_in = seconds_ff;
      set_in     = set_ff;
      case (step.op)
         OP_BYTE: begin
            unique case (state_ff)
               PS_WAIT_FIRST, PS_LOADED: begin
                  if (step.data == MAGIC_FIRST) state_in = PS_WAIT_SECOND;
               end
               PS_WAIT_SECOND: begin
                  if (step.data == MAGIC_SECOND) begin
                     state_in = PS_GATHER;
                     index_in = 2'd0;
                  end else begin
                     state_in = PS_WAIT_FIRST;
                  end
               end
               PS_GATHER: begin
                  // Bytes arrive least significant first; the fourth completes the word.
                  unique case (index_ff)
                     2'd0: gather_in[7:0]   = step.data;
                     2'd1: gather_in[15:8]  = step.data;
                     2'd2: gather_in[23:16] = step.data;
                     default: begin
                        seconds_in = {step.data, gather_ff};
                        set_in     = 1'b1;
                        state_in   = PS_LOADED;
                     end
                  endcase
                  index_in = index_ff + 2'd1;
               end
               default: state_in = PS_WAIT_FIRST;
            endcase
         end
         OP_PULSE: seconds_in = seconds_ff + 32'd1;
         default: ;
      endcase
   end

   assign time_next.seconds  = seconds_in;
   assign time_next.time_set = set_in;

endmodule

### src/pps_time_sync_receiver_unit.sv
// Time-of-day keeper fed by one request channel that carries three kinds of
// items: received serial bytes, pulse-per-second events and time queries.
// Serial bytes pass through a frame parser that looks for 0x16 followed by
// 0x03 and then collects four bytes, least significant first, which load the
// seconds count and raise time_set for good. A pulse adds one to the seconds
// count (wrapping at 2^32). A query returns the seconds count together with
// the sampled cycle count scaled by ns_per_cycle (unsigned Q8.24), shifted
// right by 24 and saturated at 2^32-1; every other item reports zero
// nanoseconds. Each item yields exactly one response showing the state after
// that item. An item passes through the input register and then the response
// register, with the parser update and the single 32x32 multiply between
// them. A new item is taken every cycle as long as the response side keeps
// up; the input register and the response register act as a two-entry
// buffer, so one stalled response still lets one more item in.
// The scale factor is written through csr_wr_en and csr_wr_data and should
// only change while no item is in flight.
module pps_time_sync_receiver_unit
   import ptsr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_op,
   input  logic [7:0]       req_byte_in,
   input  logic [31:0]      req_cycle_count,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [SEC_W-1:0] rsp_seconds_out,
   output logic [NS_W-1:0]  rsp_nanoseconds_out,
   output logic             rsp_time_set,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);

   // Scale factor register.
   logic [31:0] ns_per_cycle_ff;

   // Input register.
   logic        s1_valid_ff;
   ptsr_op_type s1_op_ff;
   logic [7:0]  s1_byte_ff;
   logic [31:0] s1_cycles_ff;

   // Response register.
   logic             rsp_valid_ff;
   logic [SEC_W-1:0] rsp_seconds_ff;
   logic [NS_W-1:0]  rsp_ns_ff;
   logic             rsp_set_ff;

   logic             advance;
   ptsr_step_type    step;
   ptsr_time_type    time_next;
   logic [63:0]      product;
   logic [NS_W-1:0]  ns_in;

   // The item in the input register moves on when the response register is
   // empty or is being emptied in this cycle.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         ns_per_cycle_ff <= NS_PER_CYCLE_RESET;
      end else if (csr_wr_en) begin
         ns_per_cycle_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) s1_valid_ff <= req_valid;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_op_ff     <= req_op;
         s1_byte_ff   <= req_byte_in;
         s1_cycles_ff <= req_cycle_count;
      end
      if (advance) begin
         rsp_seconds_ff <= time_next.seconds;
         rsp_set_ff     <= time_next.time_set;
         rsp_ns_ff      <= ns_in;
      end
   end

   // Parser and seconds count commit when the item leaves the input register.
   assign step.valid = advance;
   assign step.op    = s1_op_ff;
   assign step.data  = s1_byte_ff;

   ptsr_time_keeper u_keeper (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .time_next (time_next)
   );

   // Scaled nanoseconds: the product is Q40.24, so bits above 55 mean overflow.
   assign product = 64'(s1_cycles_ff) * 64'(ns_per_cycle_ff);

   always_comb begin
      ns_in = '0;
      if (s1_op_ff == OP_QUERY) begin
         if (product[63:FRAC_BITS+NS_W] != '0) begin
            ns_in = '1;
         end else begin
            ns_in = product[FRAC_BITS+NS_W-1:FRAC_BITS];
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_seconds_out     = rsp_seconds_ff;
   assign rsp_nanoseconds_out = rsp_ns_ff;
   assign rsp_time_set        = rsp_set_ff;

endmodule

### src/ptsr_checker.sv
module ptsr_checker
   import ptsr_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [SEC_W-1:0] rsp_seconds_out,
   input logic [NS_W-1:0]  rsp_nanoseconds_out,
   input logic             rsp_time_set
);

   logic [2:0] pending_ff, pending_in;
   logic       seen_set_ff;

   assign pending_in = pending_ff + 3'(req_valid && req_ready) - 3'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= 3'd0;
         seen_set_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         if (rsp_valid && rsp_ready && rsp_time_set) seen_set_ff <= 1'b1;
      end
   end

   // A stalled response holds its item.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seconds_out)
         && $stable(rsp_nanoseconds_out) && $stable(rsp_time_set))
      else $error("response changed while stalled");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Responses only follow accepted items, and at most two are in flight.
   a_pending: assert property (@(posedge clock) disable iff (reset)
      (pending_ff <= 3'd2) && (!rsp_valid || pending_ff != 3'd0))
      else $error("response count does not match accepted items");

   // Once time has been set it never clears.
   a_set_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_set_ff |-> rsp_time_set)
      else $error("time_set dropped after being set");

endmodule

bind pps_time_sync_receiver_unit ptsr_checker u_ptsr_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_seconds_out     (rsp_seconds_out),
   .rsp_nanoseconds_out (rsp_nanoseconds_out),
   .rsp_time_set        (rsp_time_set)
);
